@@ sv/kmbd_pkg.sv @@
`default_nettype none
package kmbd_pkg;

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_POP     = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int POS_W       = 10;
   localparam int ACC_W       = 16;
   localparam int CODE_W      = 8;
   localparam int PENDING_W   = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_CURSOR_MAX_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CURSOR_MAX_Y = 2'd1;

   localparam logic [POS_W-1:0] CURSOR_MAX_X_RESET = 10'd640;
   localparam logic [POS_W-1:0] CURSOR_MAX_Y_RESET = 10'd400;

   localparam logic [4:0] MOUSE_HEADER = 5'h1F;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [CODE_W-1:0] push_code;
   } fifo_ctl_type;

   function automatic logic signed [ACC_W-1:0] sat_add16(
      input logic signed [ACC_W-1:0] acc,
      input logic [CODE_W-1:0]       delta
   );
      logic signed [ACC_W:0] sum;
      logic signed [ACC_W:0] ext;
      ext = {{(ACC_W-CODE_W+1){delta[CODE_W-1]}}, delta};
      sum = {acc[ACC_W-1], acc} + ext;
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sat_add16 = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_add16 = sum[ACC_W-1:0];
      end
   endfunction

   function automatic logic [POS_W-1:0] clamp_to(
      input logic signed [ACC_W-1:0] acc,
      input logic [POS_W-1:0]        hi
   );
      if (acc[ACC_W-1]) begin
         clamp_to = '0;
      end else if (acc[ACC_W-2:0] > {{(ACC_W-1-POS_W){1'b0}}, hi}) begin
         clamp_to = hi;
      end else begin
         clamp_to = acc[POS_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ sv/kmbd_ifs.sv @@
`default_nettype none
interface kmbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface kmbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic       key_valid;
   logic [4:0] keys_pending;
   logic [9:0] pos_x;
   logic [9:0] pos_y;
   logic       left_button;

   modport source (output valid, output key_code, output key_valid, output keys_pending,
                   output pos_x, output pos_y, output left_button, input ready);
   modport sink (input valid, input key_code, input key_valid, input keys_pending,
                 input pos_x, input pos_y, input left_button, output ready);
endinterface

interface kmbd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [9:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/kmbd_ram.sv @@
`default_nettype none
module kmbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/kmbd_fifo.sv @@
`default_nettype none
module kmbd_fifo #(
   parameter int FIFO_DEPTH = 16,
   localparam int PTR_W = $clog2(FIFO_DEPTH),
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kmbd_pkg::fifo_ctl_type   ctl,
   output logic      [CNT_W-1:0]         count,
   output logic      [kmbd_pkg::CODE_W-1:0] head_code
);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             byp_sel_ff, byp_sel_in;
   logic [kmbd_pkg::CODE_W-1:0] byp_code_ff;
   logic [kmbd_pkg::CODE_W-1:0] ram_code;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
         wrap_inc = '0;
      end else begin
         wrap_inc = ptr + 1'b1;
      end
   endfunction

   always_comb begin
      head_in  = ctl.pop ? wrap_inc(head_ff) : head_ff;
      tail_in  = ctl.push ? wrap_inc(tail_ff) : tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
      byp_sel_in = ctl.push && (tail_ff == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         byp_sel_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         byp_sel_ff <= byp_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_code_ff <= ctl.push_code;
   end

   kmbd_ram #(
      .WIDTH (kmbd_pkg::CODE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (ctl.push_code),
      .rd_addr (head_in),
      .rd_data (ram_code)
   );

   assign count     = count_ff;
   assign head_code = byp_sel_ff ? byp_code_ff : ram_code;

endmodule
`default_nettype wire

@@ sv/keyboard_mouse_byte_decoder_unit.sv @@
// Keyboard/mouse byte decoder.
// req_if carries one word per command: opcode 0 hands in a received byte, 1 pops a
// queued scan code, 2 reads the cursor clamped to the csr limits. A header byte
// 11111xxx opens a mouse packet; the next two bytes move x and then y.
// rsp_if returns exactly one word per command: dequeued code and its valid flag,
// codes pending, clamped position and left button.
// csr_if writes cursor_max_x (index 0) and cursor_max_y (index 1); it is always
// ready and is meant to be written only while no command is in flight.
// An accepted command waits in the input register until its response word is
// registered. Throughput: one command per cycle while rsp_if is ready, set by the
// single pass from the input register to the response register and the one-write,
// one-read FIFO memory. When rsp_if stalls, the response register holds and the
// input register still takes one more command; req_if drops ready only when
// both are full. Reset (synchronous) empties the FIFO, zeroes the cursor and
// button, leaves the packet state idle and restores the limits to 640 and 400.
`default_nettype none
module keyboard_mouse_byte_decoder_unit #(
   parameter int FIFO_DEPTH = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   kmbd_req_if.sink  req_if,
   kmbd_rsp_if.source rsp_if,
   kmbd_csr_if.sink  csr_if
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic                            req_vld_ff;
   kmbd_pkg::opcode_type            req_op_ff;
   logic [kmbd_pkg::CODE_W-1:0]     req_byte_ff;

   logic                            rsp_vld_ff;
   logic [kmbd_pkg::CODE_W-1:0]     key_code_ff, key_code_in;
   logic                            key_valid_ff, key_valid_in;
   logic [kmbd_pkg::PENDING_W-1:0]  pending_ff, pending_in;
   logic [kmbd_pkg::POS_W-1:0]      pos_x_ff, pos_x_in;
   logic [kmbd_pkg::POS_W-1:0]      pos_y_ff, pos_y_in;

   logic                            packet_ff, packet_in;
   logic                            expect_dy_ff, expect_dy_in;
   logic signed [kmbd_pkg::ACC_W-1:0] acc_x_ff, acc_x_in;
   logic signed [kmbd_pkg::ACC_W-1:0] acc_y_ff, acc_y_in;
   logic                            button_ff, button_in;
   logic [kmbd_pkg::POS_W-1:0]      max_x_ff, max_y_ff;

   kmbd_pkg::fifo_ctl_type          fifo_ctl;
   logic [CNT_W-1:0]                fifo_count;
   logic [CNT_W-1:0]                count_next;
   logic [kmbd_pkg::CODE_W-1:0]     head_code;
   logic                            fifo_full, fifo_empty;
   logic                            advance;

   assign advance       = req_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready  = !req_vld_ff || advance;
   assign csr_if.ready  = 1'b1;
   assign fifo_full     = (fifo_count == CNT_W'(FIFO_DEPTH));
   assign fifo_empty    = (fifo_count == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         req_op_ff   <= kmbd_pkg::opcode_type'(req_if.opcode);
         req_byte_ff <= req_if.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= kmbd_pkg::CURSOR_MAX_X_RESET;
         max_y_ff <= kmbd_pkg::CURSOR_MAX_Y_RESET;
      end else if (csr_if.valid) begin
         if (csr_if.index == kmbd_pkg::REG_CURSOR_MAX_X) begin
            max_x_ff <= csr_if.data;
         end else if (csr_if.index == kmbd_pkg::REG_CURSOR_MAX_Y) begin
            max_y_ff <= csr_if.data;
         end
      end
   end

   always_comb begin
      packet_in          = packet_ff;
      expect_dy_in       = expect_dy_ff;
      acc_x_in           = acc_x_ff;
      acc_y_in           = acc_y_ff;
      button_in          = button_ff;
      fifo_ctl.push      = 1'b0;
      fifo_ctl.pop       = 1'b0;
      fifo_ctl.push_code = req_byte_ff;
      key_valid_in       = 1'b0;
      pos_x_in           = '0;
      pos_y_in           = '0;
      if (advance) begin
         case (req_op_ff)
            kmbd_pkg::OP_RX_BYTE: begin
               if (packet_ff) begin
                  if (expect_dy_ff) begin
                     acc_y_in     = kmbd_pkg::sat_add16(acc_y_ff, req_byte_ff);
                     expect_dy_in = 1'b0;
                     packet_in    = 1'b0;
                  end else begin
                     acc_x_in     = kmbd_pkg::sat_add16(acc_x_ff, req_byte_ff);
                     expect_dy_in = 1'b1;
                  end
               end else if (req_byte_ff[7:3] == kmbd_pkg::MOUSE_HEADER) begin
                  packet_in    = 1'b1;
                  expect_dy_in = 1'b0;
                  button_in    = req_byte_ff[1];
               end else begin
                  fifo_ctl.push = !fifo_full;
               end
            end
            kmbd_pkg::OP_POP: begin
               fifo_ctl.pop = !fifo_empty;
               key_valid_in = !fifo_empty;
            end
            kmbd_pkg::OP_READ: begin
               pos_x_in = kmbd_pkg::clamp_to(acc_x_ff, max_x_ff);
               pos_y_in = kmbd_pkg::clamp_to(acc_y_ff, max_y_ff);
               acc_x_in = kmbd_pkg::ACC_W'(pos_x_in);
               acc_y_in = kmbd_pkg::ACC_W'(pos_y_in);
            end
            default: begin
            end
         endcase
      end
      key_code_in = key_valid_in ? head_code : '0;
      count_next  = fifo_count;
      if (fifo_ctl.push) begin
         count_next = fifo_count + 1'b1;
      end else if (fifo_ctl.pop) begin
         count_next = fifo_count - 1'b1;
      end
      pending_in = kmbd_pkg::PENDING_W'(count_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_ff    <= 1'b0;
         expect_dy_ff <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         button_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         packet_ff    <= packet_in;
         expect_dy_ff <= expect_dy_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         button_ff    <= button_in;
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   logic left_button_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         key_code_ff    <= key_code_in;
         key_valid_ff   <= key_valid_in;
         pending_ff     <= pending_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         left_button_ff <= button_in;
      end
   end

   kmbd_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .count     (fifo_count),
      .head_code (head_code)
   );

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.key_code     = key_code_ff;
   assign rsp_if.key_valid    = key_valid_ff;
   assign rsp_if.keys_pending = pending_ff;
   assign rsp_if.pos_x        = pos_x_ff;
   assign rsp_if.pos_y        = pos_y_ff;
   assign rsp_if.left_button  = left_button_ff;

endmodule
`default_nettype wire

@@ dv/kmbd_checker.sv @@
`timescale 1ns / 1ps
module kmbd_checker #(
   parameter int KEY_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   kmbd_req_if  req_if,
   kmbd_rsp_if  rsp_if,
   kmbd_csr_if  csr_if,
   output int   fails,
   output int   outstanding,
   output int   checked
);

   typedef struct packed {
      logic [kmbd_pkg::CODE_W-1:0]    key_code;
      logic                           key_valid;
      logic [kmbd_pkg::PENDING_W-1:0] keys_pending;
      logic [kmbd_pkg::POS_W-1:0]     pos_x;
      logic [kmbd_pkg::POS_W-1:0]     pos_y;
      logic                           left_button;
   } decoder_word_type;

   logic [kmbd_pkg::CODE_W-1:0] key_store [KEY_DEPTH];
   int                key_head;
   int                key_tail;
   int                key_count;
   bit                in_packet;
   bit                want_dy;
   bit                left_held;
   int                mouse_x;
   int                mouse_y;
   int                limit_x;
   int                limit_y;
   int                reported;
   decoder_word_type  predicted_words [$];

   function automatic int move_saturated(input int acc,
                                         input logic [kmbd_pkg::CODE_W-1:0] delta);
      int sum;
      sum = acc + $signed(delta);
      if (sum > 32767) begin
         sum = 32767;
      end
      if (sum < -32768) begin
         sum = -32768;
      end
      return sum;
   endfunction

   function automatic int clamp_position(input int v, input int hi);
      if (v < 0) begin
         return 0;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   task automatic decode_command(input kmbd_pkg::opcode_type op,
                                 input logic [kmbd_pkg::CODE_W-1:0] b,
                                 output decoder_word_type w);
      w = '0;
      case (op)
         kmbd_pkg::OP_RX_BYTE: begin
            if (in_packet) begin
               if (want_dy) begin
                  mouse_y = move_saturated(mouse_y, b);
                  want_dy = 1'b0;
                  in_packet = 1'b0;
               end else begin
                  mouse_x = move_saturated(mouse_x, b);
                  want_dy = 1'b1;
               end
            end else if (b[7:3] == kmbd_pkg::MOUSE_HEADER) begin
               in_packet = 1'b1;
               want_dy = 1'b0;
               left_held = b[1];
            end else if (key_count < KEY_DEPTH) begin
               key_store[key_tail] = b;
               key_tail = (key_tail + 1) % KEY_DEPTH;
               key_count++;
            end
         end
         kmbd_pkg::OP_POP: begin
            if (key_count > 0) begin
               w.key_code = key_store[key_head];
               w.key_valid = 1'b1;
               key_head = (key_head + 1) % KEY_DEPTH;
               key_count--;
            end
         end
         kmbd_pkg::OP_READ: begin
            mouse_x = clamp_position(mouse_x, limit_x);
            mouse_y = clamp_position(mouse_y, limit_y);
            w.pos_x = mouse_x[kmbd_pkg::POS_W-1:0];
            w.pos_y = mouse_y[kmbd_pkg::POS_W-1:0];
         end
         default: begin
         end
      endcase
      w.keys_pending = key_count[kmbd_pkg::PENDING_W-1:0];
      w.left_button = left_held;
   endtask

   always @(posedge clock) begin
      decoder_word_type seen;
      decoder_word_type want;
      if (reset) begin
         key_head = 0;
         key_tail = 0;
         key_count = 0;
         in_packet = 1'b0;
         want_dy = 1'b0;
         left_held = 1'b0;
         mouse_x = 0;
         mouse_y = 0;
         limit_x = int'(kmbd_pkg::CURSOR_MAX_X_RESET);
         limit_y = int'(kmbd_pkg::CURSOR_MAX_Y_RESET);
         predicted_words.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.key_code = rsp_if.key_code;
            seen.key_valid = rsp_if.key_valid;
            seen.keys_pending = rsp_if.keys_pending;
            seen.pos_x = rsp_if.pos_x;
            seen.pos_y = rsp_if.pos_y;
            seen.left_button = rsp_if.left_button;
            if (predicted_words.size() == 0) begin
               fails++;
               if (reported < 10) begin
                  $display("%0t: response word with nothing pending: key %02h/%0b pending %0d",
                           $realtime, seen.key_code, seen.key_valid, seen.keys_pending);
               end
               reported++;
            end else begin
               want = predicted_words.pop_front();
               checked++;
               if (seen !== want) begin
                  fails++;
                  if (reported < 10) begin
                     $display("%0t: mismatch expected key %02h/%0b pending %0d pos %0d,%0d btn %0b",
                              $realtime, want.key_code, want.key_valid, want.keys_pending,
                              want.pos_x, want.pos_y, want.left_button);
                     $display("%0t:          actual   key %02h/%0b pending %0d pos %0d,%0d btn %0b",
                              $realtime, seen.key_code, seen.key_valid, seen.keys_pending,
                              seen.pos_x, seen.pos_y, seen.left_button);
                  end
                  reported++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            decode_command(kmbd_pkg::opcode_type'(req_if.opcode), req_if.rx_byte, want);
            predicted_words.push_back(want);
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               kmbd_pkg::REG_CURSOR_MAX_X: limit_x = int'(csr_if.data);
               kmbd_pkg::REG_CURSOR_MAX_Y: limit_y = int'(csr_if.data);
               default: begin
               end
            endcase
         end
      end
      outstanding = predicted_words.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

   localparam int KEY_DEPTH   = 16;
   localparam int CODE_W      = kmbd_pkg::CODE_W;
   localparam int CSR_INDEX_W = kmbd_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = kmbd_pkg::CSR_DATA_W;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   src_idle;
   int   snk_idle;
   int   words_sent;
   int   settings_used;
   int   fails;
   int   outstanding;
   int   checked;

   kmbd_req_if req_bus ();
   kmbd_rsp_if rsp_bus ();
   kmbd_csr_if csr_bus ();

   always #1 clock = ~clock;

   keyboard_mouse_byte_decoder_unit #(
      .FIFO_DEPTH(KEY_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   kmbd_checker #(
      .KEY_DEPTH(KEY_DEPTH)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_bus),
      .rsp_if     (rsp_bus),
      .csr_if     (csr_bus),
      .fails      (fails),
      .outstanding(outstanding),
      .checked    (checked)
   );

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= snk_idle);
      end
   end

   task automatic send_word(input kmbd_pkg::opcode_type op, input logic [CODE_W-1:0] b);
      while ($urandom_range(99) < src_idle) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_packet(input logic [CODE_W-1:0] dx, input logic [CODE_W-1:0] dy);
      send_word(kmbd_pkg::OP_RX_BYTE, {kmbd_pkg::MOUSE_HEADER, 3'($urandom)});
      send_word(kmbd_pkg::OP_RX_BYTE, dx);
      send_word(kmbd_pkg::OP_RX_BYTE, dy);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   task automatic set_cursor_limits(input int x, input int y, input bit spare);
      wait_drained();
      write_reg(kmbd_pkg::REG_CURSOR_MAX_X, x[CSR_DATA_W-1:0]);
      write_reg(kmbd_pkg::REG_CURSOR_MAX_Y, y[CSR_DATA_W-1:0]);
      if (spare) begin
         write_reg(REG_SPARE_2, CSR_DATA_W'($urandom));
         write_reg(REG_SPARE_3, CSR_DATA_W'($urandom));
      end
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      int stop;
      int kind;
      stop = words_sent + count;
      while (words_sent < stop) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            send_packet(CODE_W'($urandom), CODE_W'($urandom));
         end else if (kind < 55) begin
            repeat ($urandom_range(1, 10)) begin
               send_word(kmbd_pkg::OP_RX_BYTE, CODE_W'($urandom_range(8'hF7)));
            end
         end else if (kind < 75) begin
            repeat ($urandom_range(1, 12)) send_word(kmbd_pkg::OP_POP, CODE_W'($urandom));
         end else if (kind < 85) begin
            send_word(kmbd_pkg::OP_READ, CODE_W'($urandom));
         end else if (kind < 95) begin
            send_word(kmbd_pkg::opcode_type'($urandom_range(3)), CODE_W'($urandom));
         end else begin
            send_word(kmbd_pkg::OP_NONE, CODE_W'($urandom));
         end
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.opcode <= kmbd_pkg::OP_RX_BYTE;
      req_bus.rx_byte <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= kmbd_pkg::REG_CURSOR_MAX_X;
      csr_bus.data <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settings_used = 1;

      send_word(kmbd_pkg::OP_READ, 8'h00);
      send_word(kmbd_pkg::OP_POP, 8'hFF);
      send_word(kmbd_pkg::OP_NONE, 8'hFF);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'h00);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'hF7);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'h80);
      repeat (4) send_word(kmbd_pkg::OP_POP, 8'h00);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'hFA);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'h7F);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'h80);
      send_word(kmbd_pkg::OP_READ, 8'hFF);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'hF8);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'hFF);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'hF8);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'hFF);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'h01);
      send_word(kmbd_pkg::OP_POP, 8'h00);
      send_word(kmbd_pkg::OP_RX_BYTE, 8'h7F);
      send_word(kmbd_pkg::OP_READ, 8'h00);
      send_word(kmbd_pkg::OP_NONE, 8'h00);
      repeat (KEY_DEPTH + 2) begin
         send_word(kmbd_pkg::OP_RX_BYTE, CODE_W'($urandom_range(8'hF7)));
      end
      repeat (KEY_DEPTH + 1) send_word(kmbd_pkg::OP_POP, 8'h00);

      src_idle = 6;
      snk_idle = 88;
      set_cursor_limits(1023, 0, 1'b1);
      run_random(110);

      src_idle = 88;
      snk_idle = 6;
      set_cursor_limits(0, 1023, 1'b0);
      run_random(110);

      src_idle = 0;
      snk_idle = 0;
      set_cursor_limits($urandom_range(1, 1022), $urandom_range(1, 1022), 1'b0);
      repeat (15) begin
         send_packet(CODE_W'($urandom_range(8'h78, 8'h7F)),
                     CODE_W'($urandom_range(8'h80, 8'h87)));
      end
      send_word(kmbd_pkg::OP_READ, 8'h00);
      run_random(110);

      wait_drained();
      $display("%0d command words sent, %0d responses checked over %0d cursor limit settings",
               words_sent, checked, settings_used);
      $display("covered key queue full and empty, mouse packets, cursor clamping, stalls");
      if (fails == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
